>>> hdl/scoped_symbol_stack_assert.svh
// Assertion macros used by the checker file.
`ifndef SCOPED_SYMBOL_STACK_ASSERT_SVH
`define SCOPED_SYMBOL_STACK_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SSS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scoped symbol stack check failed");

// Next-cycle implication, held off during reset.
`define SSS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scoped symbol stack check failed");

`endif

>>> hdl/sss_pkg.sv
`default_nettype none
package sss_pkg;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned MAX_LEVEL_DEF   = 255;

    localparam logic [2:0] OP_INSERT     = 3'd0;
    localparam logic [2:0] OP_LOOKUP_ALL = 3'd1;
    localparam logic [2:0] OP_LOOKUP_CUR = 3'd2;
    localparam logic [2:0] OP_ENTER      = 3'd3;
    localparam logic [2:0] OP_EXIT       = 3'd4;
    localparam logic [2:0] OP_MARK       = 3'd5;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_DUP  = 3'd1;
    localparam logic [2:0] ST_MISS = 3'd2;
    localparam logic [2:0] ST_FULL = 3'd3;
    localparam logic [2:0] ST_OVER = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MARK
    } t_state;

    typedef struct packed {
        logic [2:0]  value_type;
        logic [1:0]  symbol_kind;
        logic        init_flag;
        logic        const_flag;
        logic [15:0] decl_line;
    } t_attr;

    typedef struct packed {
        logic [2:0]  operation;
        logic [63:0] name_key;
        logic [2:0]  value_type;
        logic [1:0]  symbol_kind;
        logic        init_flag;
        logic        const_flag;
        logic [15:0] decl_line;
        logic [5:0]  target_index;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  hit_index;
        logic [2:0]  hit_type;
        logic [1:0]  hit_kind;
        logic        hit_initialized;
        logic        hit_const;
        logic [15:0] hit_line;
        logic [7:0]  hit_scope;
        logic [7:0]  level_now;
        logic [6:0]  entry_count;
    } t_out;

    function automatic t_out f_none(input logic [2:0] status, input logic [7:0] level,
                                    input logic [6:0] count);
        t_out res;
        res             = '0;
        res.status      = status;
        res.level_now   = level;
        res.entry_count = count;
        return res;
    endfunction

    function automatic t_out f_hit(input logic [2:0] status, input logic [5:0] idx,
                                   input t_attr attr, input logic [7:0] scope,
                                   input logic [7:0] level, input logic [6:0] count);
        t_out res;
        res                 = '0;
        res.status          = status;
        res.hit_index       = idx;
        res.hit_type        = attr.value_type;
        res.hit_kind        = attr.symbol_kind;
        res.hit_initialized = attr.init_flag;
        res.hit_const       = attr.const_flag;
        res.hit_line        = attr.decl_line;
        res.hit_scope       = scope;
        res.level_now       = level;
        res.entry_count     = count;
        return res;
    endfunction

endpackage
`default_nettype wire

>>> hdl/sss_ram.sv
`default_nettype none
module sss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

>>> hdl/scoped_symbol_stack.sv
// Enter, unused codes and out-of-range mark give o_done in the cycle after start; mark
// in range reads the entry, then writes it back with init_flag set in S_MARK; insert,
// lookups and exit read one entry from the shared table RAM and compare it per cycle.
// busy is high while a mark or a table scan runs; a new transaction is taken the cycle o_done shows.
// Results cannot be stalled. Synchronous active-low reset empties the table and
// returns to global scope; no clearing pass is needed.
`default_nettype none
module scoped_symbol_stack #(
    parameter int unsigned TABLE_DEPTH = sss_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_LEVEL   = sss_pkg::MAX_LEVEL_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    input  wire sss_pkg::t_in i_cmd,
    output logic              busy,
    output logic              o_done,
    output sss_pkg::t_out     o_result
);

    localparam int IW     = $clog2(TABLE_DEPTH);
    localparam int CW     = $clog2(TABLE_DEPTH + 1);
    localparam int LW     = $clog2(MAX_LEVEL + 1);
    localparam int ATTR_W = $bits(sss_pkg::t_attr);
    localparam int EW     = 64 + ATTR_W + LW;
    localparam int CMPW   = (CW > 6) ? CW : 6;

    sss_pkg::t_state r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic [63:0]     r_key, n_key;
    sss_pkg::t_attr  r_attr, n_attr;
    logic [5:0]      r_tgt, n_tgt;
    logic [CW-1:0]   r_fill, n_fill;
    logic [LW-1:0]   r_level, n_level;
    logic [IW-1:0]   r_addr, n_addr;
    logic [IW-1:0]   r_pidx, n_pidx;
    logic [CW-1:0]   r_left, n_left;
    logic            r_pend, n_pend;
    sss_pkg::t_out   r_out, n_out;
    logic            r_done, n_done;

    logic            ram_we;
    logic [IW-1:0]   ram_waddr;
    logic [EW-1:0]   ram_wdata;
    logic            ram_re;
    logic [IW-1:0]   ram_raddr;
    logic [EW-1:0]   ram_rdata;

    logic [63:0]     d_key;
    sss_pkg::t_attr  d_attr;
    sss_pkg::t_attr  w_mark_attr;
    logic [LW-1:0]   d_scope;
    logic            v_hit;
    logic            v_stop;

    sss_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign d_key   = ram_rdata[EW-1 -: 64];
    assign d_attr  = sss_pkg::t_attr'(ram_rdata[LW +: ATTR_W]);
    assign d_scope = ram_rdata[LW-1:0];

    always_comb begin
        w_mark_attr           = d_attr;
        w_mark_attr.init_flag = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sss_pkg::S_IDLE;
            r_fill  <= '0;
            r_level <= '0;
            r_pend  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_level <= n_level;
            r_pend  <= n_pend;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_attr <= n_attr;
        r_tgt  <= n_tgt;
        r_addr <= n_addr;
        r_pidx <= n_pidx;
        r_left <= n_left;
        r_out  <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_key     = r_key;
        n_attr    = r_attr;
        n_tgt     = r_tgt;
        n_fill    = r_fill;
        n_level   = r_level;
        n_addr    = r_addr;
        n_pidx    = r_pidx;
        n_left    = r_left;
        n_pend    = r_pend;
        n_out     = r_out;
        n_done    = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_fill[IW-1:0];
        ram_wdata = {r_key, r_attr, r_level};
        ram_re    = 1'b0;
        ram_raddr = r_addr;
        v_hit     = 1'b0;
        v_stop    = 1'b0;

        case (r_state)
            sss_pkg::S_IDLE: begin
                if (start) begin
                    n_op                  = i_cmd.operation;
                    n_key                 = i_cmd.name_key;
                    n_attr.value_type     = i_cmd.value_type;
                    n_attr.symbol_kind    = i_cmd.symbol_kind;
                    n_attr.init_flag      = i_cmd.init_flag;
                    n_attr.const_flag     = i_cmd.const_flag;
                    n_attr.decl_line      = i_cmd.decl_line;
                    n_tgt                 = i_cmd.target_index;
                    case (i_cmd.operation)
                        sss_pkg::OP_INSERT, sss_pkg::OP_LOOKUP_ALL,
                        sss_pkg::OP_LOOKUP_CUR, sss_pkg::OP_EXIT: begin
                            n_state = sss_pkg::S_SCAN;
                            n_left  = r_fill;
                            n_addr  = IW'(r_fill - 1'b1);
                            n_pend  = 1'b0;
                        end
                        sss_pkg::OP_ENTER: begin
                            n_done = 1'b1;
                            if (r_level >= LW'(MAX_LEVEL)) begin
                                n_out = sss_pkg::f_none(sss_pkg::ST_OVER, 8'(r_level),
                                                        7'(r_fill));
                            end else begin
                                n_level = r_level + 1'b1;
                                n_out   = sss_pkg::f_none(sss_pkg::ST_OK, 8'(n_level),
                                                          7'(r_fill));
                            end
                        end
                        sss_pkg::OP_MARK: begin
                            if (CMPW'(i_cmd.target_index) < CMPW'(r_fill)) begin
                                ram_re    = 1'b1;
                                ram_raddr = IW'(i_cmd.target_index);
                                n_state   = sss_pkg::S_MARK;
                            end else begin
                                n_done = 1'b1;
                                n_out  = sss_pkg::f_none(sss_pkg::ST_MISS, 8'(r_level),
                                                         7'(r_fill));
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_out  = sss_pkg::f_none(sss_pkg::ST_OK, 8'(r_level),
                                                     7'(r_fill));
                        end
                    endcase
                end
            end

            sss_pkg::S_MARK: begin
                ram_we    = 1'b1;
                ram_waddr = IW'(r_tgt);
                ram_wdata = {d_key, w_mark_attr, d_scope};
                n_done    = 1'b1;
                n_state   = sss_pkg::S_IDLE;
                n_out     = sss_pkg::f_hit(sss_pkg::ST_OK, r_tgt, w_mark_attr, 8'(d_scope),
                                           8'(r_level), 7'(r_fill));
            end

            sss_pkg::S_SCAN: begin
                if (r_pend) begin
                    case (r_op)
                        sss_pkg::OP_LOOKUP_ALL: begin
                            v_hit = (d_key == r_key);
                        end
                        sss_pkg::OP_EXIT: begin
                            if (d_scope == r_level) begin
                                n_fill = r_fill - 1'b1;
                            end else begin
                                v_stop = 1'b1;
                            end
                        end
                        default: begin
                            if (d_scope < r_level) begin
                                v_stop = 1'b1;
                            end else if (d_scope == r_level && d_key == r_key) begin
                                v_hit = 1'b1;
                            end
                        end
                    endcase
                end

                if (v_hit) begin
                    n_done  = 1'b1;
                    n_state = sss_pkg::S_IDLE;
                    n_out   = sss_pkg::f_hit((r_op == sss_pkg::OP_INSERT) ? sss_pkg::ST_DUP
                                                                          : sss_pkg::ST_OK,
                                             6'(r_pidx), d_attr, 8'(d_scope),
                                             8'(r_level), 7'(r_fill));
                end else if (!v_stop && r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_addr;
                    n_addr    = r_addr - 1'b1;
                    n_left    = r_left - 1'b1;
                    n_pidx    = r_addr;
                    n_pend    = 1'b1;
                end else begin
                    n_done  = 1'b1;
                    n_state = sss_pkg::S_IDLE;
                    n_pend  = 1'b0;
                    case (r_op)
                        sss_pkg::OP_INSERT: begin
                            if (r_fill >= CW'(TABLE_DEPTH)) begin
                                n_out = sss_pkg::f_none(sss_pkg::ST_FULL, 8'(r_level),
                                                        7'(r_fill));
                            end else begin
                                ram_we = 1'b1;
                                n_fill = r_fill + 1'b1;
                                n_out  = sss_pkg::f_hit(sss_pkg::ST_OK, 6'(r_fill), r_attr,
                                                        8'(r_level), 8'(r_level),
                                                        7'(n_fill));
                            end
                        end
                        sss_pkg::OP_EXIT: begin
                            if (r_level != '0) begin
                                n_level = r_level - 1'b1;
                            end
                            n_out = sss_pkg::f_none(sss_pkg::ST_OK, 8'(n_level), 7'(n_fill));
                        end
                        default: begin
                            n_out = sss_pkg::f_none(sss_pkg::ST_MISS, 8'(r_level),
                                                    7'(r_fill));
                        end
                    endcase
                end
            end

            default: begin
                n_state = sss_pkg::S_IDLE;
            end
        endcase
    end

    assign busy     = (r_state != sss_pkg::S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
`default_nettype wire

>>> hdl/sss_chk.sv
`default_nettype none
`include "scoped_symbol_stack_assert.svh"
module sss_chk #(
    parameter int unsigned TABLE_DEPTH = sss_pkg::TABLE_DEPTH_DEF,
    parameter int unsigned MAX_LEVEL   = sss_pkg::MAX_LEVEL_DEF
) (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          start,
    input wire logic          busy,
    input wire sss_pkg::t_in  i_cmd,
    input wire logic          o_done,
    input wire sss_pkg::t_out o_result
);

    `SSS_ASSERT_NEXT(a_enter_one_cycle, i_clk, i_rst_n, start && !busy && i_cmd.operation == sss_pkg::OP_ENTER, o_done)
    `SSS_ASSERT_NOW(a_done_when_free, i_clk, i_rst_n, o_done, !busy)
    `SSS_ASSERT_NOW(a_miss_no_entry, i_clk, i_rst_n, o_done && (o_result.status == sss_pkg::ST_MISS || o_result.status == sss_pkg::ST_FULL || o_result.status == sss_pkg::ST_OVER), o_result.hit_index == 6'd0 && o_result.hit_line == 16'd0 && o_result.hit_scope == 8'd0)
    `SSS_ASSERT_NOW(a_full_count, i_clk, i_rst_n, o_done && o_result.status == sss_pkg::ST_FULL, o_result.entry_count == 7'(TABLE_DEPTH))
    `SSS_ASSERT_NOW(a_over_level, i_clk, i_rst_n, o_done && o_result.status == sss_pkg::ST_OVER, o_result.level_now == 8'(MAX_LEVEL))

endmodule

bind scoped_symbol_stack sss_chk #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_LEVEL   (MAX_LEVEL)
) u_sss_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire
